// ===== hw/rtl/mmnp_pkg.sv =====
// Shared types, codes and constant tables of the music macro note parser.
`timescale 1ns / 1ps
`default_nettype none

package mmnp_pkg;

    // Status codes of a result
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_NUMBER = 2'd2;
    localparam logic [1:0] ST_DIVIDE = 2'd3;

    // Accidental codes
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_SHARP = 2'd1;
    localparam logic [1:0] ACC_FLAT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMPO  = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_OCTAVE = 2'd2;
    localparam logic [1:0] CFG_VOLUME = 2'd3;

    // Divider widths: dividend shift register, divisor, quotient, step counter
    localparam int DIV_X_W = 34;
    localparam int DIV_D_W = 47;
    localparam int DIV_Q_W = 34;
    localparam int DIV_C_W = 6;

    localparam logic [17:0] MS_PER_WHOLE = 18'd240000;

    typedef enum logic [2:0] {
        PH_START,
        PH_LETTER,
        PH_ACC,
        PH_DIGITS,
        PH_DOTS,
        PH_ARG,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DUR_START,
        BK_DUR_WAIT,
        BK_PITCH,
        BK_OUT
    } back_state_t;

    // One parsed token handed from front to back
    typedef struct packed {
        logic [7:0]  letter;
        logic [1:0]  accidental;
        logic [15:0] number;
        logic        length_given;
        logic [3:0]  dots;
        logic [1:0]  err;
    } token_t;

    function automatic logic [3:0] semitone_of(input logic [2:0] idx);
        logic [3:0] s;
        unique case (idx)
            3'd0: s = 4'd9;
            3'd1: s = 4'd11;
            3'd2: s = 4'd0;
            3'd3: s = 4'd2;
            3'd4: s = 4'd4;
            3'd5: s = 4'd5;
            3'd6: s = 4'd7;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // 440*2^(r/12)*4096 truncated; a right shift by 16-octave gives the
    // truncated pitch of any octave from 0 to 16
    function automatic logic [21:0] pitch_top(input logic [3:0] r);
        logic [21:0] b;
        unique case (r)
            4'd0:  b = 22'd1802240;
            4'd1:  b = 22'd1909406;
            4'd2:  b = 22'd2022946;
            4'd3:  b = 22'd2143236;
            4'd4:  b = 22'd2270680;
            4'd5:  b = 22'd2405701;
            4'd6:  b = 22'd2548752;
            4'd7:  b = 22'd2700308;
            4'd8:  b = 22'd2860877;
            4'd9:  b = 22'd3030994;
            4'd10: b = 22'd3211226;
            4'd11: b = 22'd3402176;
            default: b = 22'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmnp_front.sv =====
// Character parser: builds one token from its characters and pushes it on token end.
`timescale 1ns / 1ps
`default_nettype none

module mmnp_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,   // char_code[7:0]
    input  wire                  s_tlast,   // token_end
    output logic                 push,
    output mmnp_pkg::token_t     push_tok,
    input  wire                  full
);
    import mmnp_pkg::*;

    phase_t     phase_reg, phase_next;
    token_t     tok_reg, tok_next;
    logic [7:0] c;
    logic       digit;
    logic [19:0] acc_mul;
    logic [19:0] acc_sum;
    logic [15:0] acc_sat;
    logic       accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign digit    = (c >= 8'h30) && (c <= 8'h39);

    // Saturating decimal accumulate
    always_comb
    begin
        acc_mul = {4'd0, tok_reg.number} * 20'd10;
        acc_sum = acc_mul + {12'd0, c - 8'h30};
        acc_sat = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];
    end

    // Advance the parse on one character
    always_comb
    begin
        tok_next   = tok_reg;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_START:
            begin
                tok_next.letter = c;
                if (c >= 8'h41 && c <= 8'h47)
                    phase_next = PH_LETTER;
                else if (c == 8'h4C || c == 8'h4F || c == 8'h54 || c == 8'h50 || c == 8'h56)
                    phase_next = PH_ARG;
                else
                    phase_next = PH_SKIP;
            end
            PH_LETTER, PH_ACC:
            begin
                if (phase_reg == PH_LETTER && (c == 8'h23 || c == 8'h2B || c == 8'h2D))
                begin
                    tok_next.accidental = (c == 8'h2D) ? ACC_FLAT : ACC_SHARP;
                    phase_next = PH_ACC;
                end
                else if (digit)
                begin
                    tok_next.number       = acc_sat;
                    tok_next.length_given = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else if (c == 8'h2E)
                begin
                    tok_next.dots = 4'd1;
                    phase_next = PH_DOTS;
                end
                else
                begin
                    if (tok_reg.err == ST_OK)
                        tok_next.err = ST_SYNTAX;
                    phase_next = PH_SKIP;
                end
            end
            PH_DIGITS:
            begin
                if (digit)
                    tok_next.number = acc_sat;
                else if (c == 8'h2E)
                begin
                    tok_next.dots = 4'd1;
                    phase_next = PH_DOTS;
                end
                else if (tok_reg.err == ST_OK)
                    tok_next.err = ST_NUMBER;
            end
            PH_DOTS:
            begin
                if (c == 8'h2E)
                begin
                    if (tok_reg.dots != 4'd15)
                        tok_next.dots = tok_reg.dots + 4'd1;
                end
                else
                begin
                    if (tok_reg.err == ST_OK)
                        tok_next.err = ST_SYNTAX;
                    phase_next = PH_SKIP;
                end
            end
            PH_ARG:
            begin
                if (digit)
                    tok_next.number = acc_sat;
                else if (tok_reg.err == ST_OK)
                    tok_next.err = ST_NUMBER;
            end
            default:
            begin
            end
        endcase
    end

    assign push     = accept && s_tlast;
    assign push_tok = tok_next;

    // Hold the token under construction; clear it after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            tok_reg   <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                phase_reg <= PH_START;
                tok_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                tok_reg   <= tok_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmnp_queue.sv =====
// Two-entry token queue between the parser and the executor.
`timescale 1ns / 1ps
`default_nettype none

module mmnp_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  mmnp_pkg::token_t  push_tok,
    output logic              full,
    input  wire               pop,
    output logic              not_empty,
    output mmnp_pkg::token_t  head_tok
);
    import mmnp_pkg::*;

    token_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_tok  = mem_reg[rd_ptr_reg];

    // Store pushed tokens
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmnp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mmnp_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  [mmnp_pkg::DIV_X_W-1:0] dividend,
    input  wire  [mmnp_pkg::DIV_D_W-1:0] divisor,
    input  wire  [mmnp_pkg::DIV_C_W-1:0] steps,
    output logic                         done,
    output logic [mmnp_pkg::DIV_Q_W-1:0] quotient
);
    import mmnp_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic [DIV_X_W-1:0] xs_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0] q_reg;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    assign trial    = {rem_reg, xs_reg[DIV_X_W-1]};
    assign ge       = trial >= {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == {{(DIV_C_W-1){1'b0}}, 1'b1})
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    // Shift one dividend bit in and subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xs_reg  <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            xs_reg  <= {xs_reg[DIV_X_W-2:0], 1'b0};
            rem_reg <= ge ? (trial[DIV_D_W-1:0] - d_reg) : trial[DIV_D_W-1:0];
            q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmnp_back.sv =====
// Token executor: tracks tempo, length, octave and volume and computes each tone.
`timescale 1ns / 1ps
`default_nettype none

module mmnp_back #(
    parameter int MAX_DOTS   = 7,
    parameter int OCTAVE_MAX = 15
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_we,
    input  wire  [1:0]        cfg_index,
    input  wire  [15:0]       cfg_data,
    input  wire               q_not_empty,
    input  mmnp_pkg::token_t  q_tok,
    output logic              q_pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [63:0]       m_tdata
);
    import mmnp_pkg::*;

    localparam logic [3:0] OCT_MAX = 4'(OCTAVE_MAX);
    localparam logic [3:0] DOT_MAX = 4'(MAX_DOTS);

    back_state_t state_reg, state_next;

    logic [15:0] tempo_reg;
    logic [15:0] length_reg;
    logic [3:0]  octave_reg;
    logic [15:0] volume_reg;

    logic        is_note_reg;
    logic [7:0]  n_reg;
    logic [15:0] len_reg;
    logic [3:0]  dots_reg;
    logic [31:0] prod_reg;
    logic [DIV_Q_W-1:0] num_reg;

    logic        res_valid_reg;
    logic [21:0] freq_reg;
    logic [18:0] ms_reg;
    logic [15:0] vol_reg;
    logic [1:0]  st_reg;

    logic        head_note;
    logic [7:0]  head_n;
    logic [15:0] head_len;
    logic        slot_free;

    logic               div_start;
    logic [DIV_X_W-1:0] div_x;
    logic [DIV_D_W-1:0] div_d;
    logic [DIV_C_W-1:0] div_steps;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_q;

    logic [7:0]  pm;
    logic [15:0] pm_scaled;
    logic [4:0]  poc;
    logic [3:0]  prem;
    logic [21:0] ptop;
    logic [15:0] dot_mask;

    assign slot_free = !res_valid_reg || m_tready;
    assign head_note = (q_tok.letter >= 8'h41) && (q_tok.letter <= 8'h47);
    assign head_len  = q_tok.length_given ? q_tok.number : length_reg;

    // Note number of the head token
    always_comb
    begin
        head_n = 8'({4'd0, octave_reg} * 8'd12)
            + {4'd0, semitone_of(3'(q_tok.letter - 8'h41))} + 8'd1;
        if (q_tok.accidental == ACC_SHARP)
            head_n = head_n + 8'd1;
        else if (q_tok.accidental == ACC_FLAT)
            head_n = head_n - 8'd1;
    end

    // Split n+2 into octave and semitone, pick the top-octave pitch
    always_comb
    begin
        pm        = n_reg + 8'd2;
        pm_scaled = {8'd0, pm} * 16'd171;
        poc       = pm_scaled[15:11];
        prem      = 4'(pm - 8'({3'd0, poc} * 8'd12));
        ptop      = pitch_top(prem);
        dot_mask  = 16'((17'd2 << dots_reg) - 17'd1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    if (q_tok.err != ST_OK)
                        state_next = BK_OUT;
                    else if (head_note)
                        state_next = (q_tok.dots > DOT_MAX) ? BK_OUT : BK_MUL;
                    else if (q_tok.letter == 8'h50 && q_tok.number != 16'd0)
                        state_next = BK_MUL;
                    else
                        state_next = BK_OUT;
                end
            end
            BK_MUL:
                state_next = BK_DUR_START;
            BK_DUR_START:
                state_next = (prod_reg == 32'd0) ? BK_OUT : BK_DUR_WAIT;
            BK_DUR_WAIT:
            begin
                if (div_done)
                    state_next = (is_note_reg && n_reg != 8'd0) ? BK_PITCH : BK_OUT;
            end
            BK_PITCH:
                state_next = BK_OUT;
            BK_OUT:
            begin
                if (slot_free)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs and divider operands
    always_comb
    begin
        q_pop     = (state_reg == BK_IDLE) && q_not_empty;
        div_start = (state_reg == BK_DUR_START) && (prod_reg != 32'd0);
        div_x     = num_reg;
        div_d     = DIV_D_W'({prod_reg, 15'd0} >> (5'd15 - {1'b0, dots_reg}));
        div_steps = DIV_C_W'(DIV_Q_W);
    end

    mmnp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_x),
        .divisor  (div_d),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    // Running state and configuration loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg  <= 16'd120;
            length_reg <= 16'd4;
            octave_reg <= (4'd4 > OCT_MAX) ? OCT_MAX : 4'd4;
            volume_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMPO:  tempo_reg  <= cfg_data;
                CFG_LENGTH: length_reg <= {9'd0, cfg_data[6:0]};
                CFG_OCTAVE: octave_reg <= (cfg_data[3:0] > OCT_MAX) ? OCT_MAX : cfg_data[3:0];
                CFG_VOLUME: volume_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else if (q_pop && q_tok.err == ST_OK && !head_note)
        begin
            priority case (q_tok.letter)
                8'h4C: length_reg <= q_tok.number;
                8'h4F: octave_reg <= (q_tok.number > {12'd0, OCT_MAX}) ? OCT_MAX
                                     : q_tok.number[3:0];
                8'h54: tempo_reg  <= q_tok.number;
                8'h56: volume_reg <= q_tok.number;
                8'h3C: if (octave_reg != 4'd0) octave_reg <= octave_reg - 4'd1;
                8'h3E: if (octave_reg < OCT_MAX) octave_reg <= octave_reg + 4'd1;
                default:
                begin
                end
            endcase
        end
    end

    // Token operands and result fields
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    is_note_reg <= head_note;
                    n_reg       <= head_n;
                    len_reg     <= head_note ? head_len : q_tok.number;
                    dots_reg    <= head_note ? q_tok.dots : 4'd0;
                    ms_reg      <= 19'd0;
                    vol_reg     <= 16'd0;
                    if (q_tok.err != ST_OK)
                    begin
                        freq_reg <= 22'd0;
                        st_reg   <= q_tok.err;
                    end
                    else if (head_note && q_tok.dots > DOT_MAX)
                    begin
                        freq_reg <= 22'd0;
                        st_reg   <= ST_DIVIDE;
                    end
                    else
                    begin
                        freq_reg <= head_note ? 22'd0 : 22'd1;
                        st_reg   <= ST_OK;
                    end
                end
            end
            BK_MUL:
            begin
                prod_reg <= {16'd0, len_reg} * {16'd0, tempo_reg};
                num_reg  <= DIV_Q_W'({18'd0, dot_mask} * {16'd0, MS_PER_WHOLE});
            end
            BK_DUR_START:
            begin
                if (prod_reg == 32'd0)
                begin
                    freq_reg <= 22'd0;
                    st_reg   <= ST_DIVIDE;
                end
            end
            BK_DUR_WAIT:
            begin
                if (div_done)
                begin
                    ms_reg <= div_q[18:0];
                    if (is_note_reg)
                        vol_reg <= volume_reg;
                end
            end
            BK_PITCH:
                freq_reg <= ptop >> (5'd16 - poc);
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == BK_OUT && slot_free)
            res_valid_reg <= 1'b1;
        else if (m_tready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_OUT && slot_free)
            m_tdata <= {5'd0, st_reg, vol_reg, ms_reg, freq_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    assign m_tvalid = res_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/music_macro_note_parser.sv =====
// After its last character a note's tone passes the pop, the multiply state,
// the divider start and run for the duration, the pitch table lookup and
// shift, then the output register; a pause skips the pitch step, other tokens
// go from the pop and a zero divisor from the divider start to the output
// register. Throughput: one character per cycle while the two-entry token queue
// has room; a new token is popped once the last result is in the output register.
// Reset (asynchronous, active low) loads tempo 120, length 4, octave 4, volume 100.
`timescale 1ns / 1ps
`default_nettype none

module music_macro_note_parser #(
    parameter int MAX_DOTS   = 7,
    parameter int OCTAVE_MAX = 15
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // char_code[7:0]
    input  wire         s_tlast,    // token_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,    // frequency_hz[21:0], duration_ms[40:22],
                                    // tone_volume[56:41], status[58:57]
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import mmnp_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   not_empty;
    token_t push_tok;
    token_t head_tok;

    mmnp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_tok (push_tok),
        .full     (full)
    );

    mmnp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_tok  (head_tok)
    );

    mmnp_back #(
        .MAX_DOTS   (MAX_DOTS),
        .OCTAVE_MAX (OCTAVE_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (not_empty),
        .q_tok       (head_tok),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
